### hw/rtl/preemptive_priority_scheduler_macros.svh
// assertion macros for the scheduler
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PPS_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`else

`define PPS_ASSERT_NOW(label, clk, rst_n, cond, expr, msg)
`define PPS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)

`endif

`endif

### hw/rtl/pps_pkg.sv
package pps_pkg;

    localparam int TICK_W = 20;
    localparam logic [TICK_W-1:0] TICK_MAX = 20'hFFFFF;
    localparam int FIN_W = 5;
    localparam logic [FIN_W-1:0] FIN_MAX = 5'd31;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // one table row as stored in the slot memory
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] remaining;
    } slot_entry_t;

    // controls from the sequencer to the picker
    typedef struct packed {
        logic clear;
        logic eval;
    } pick_ctl_t;

endpackage

### hw/rtl/preemptive_priority_scheduler.sv
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | command, slot, arrival_tick, burst_ticks,
//          |                      | priority_level
// out      | out_valid / out_stall| running_slot, idle, finished,
//          |                      | completion_tick, waiting_ticks,
//          |                      | turnaround_ticks, all_done
// cfg      | cfg_wr_en            | cfg_wr_data (process_count)
//
// a load item gives no result and does not stall the input
// a tick item stalls the input while it runs, n = slots in use:
// n memory reads, one per cycle, then judge the last read, leave scan, update, emit
// reset clears control, tick, finished count, process count and loaded bits, not the slot memory
// a held result sits in the output register; loads and the next scan go on,
// only the result hand-off of a later tick waits for out_stall to drop
module preemptive_priority_scheduler #(
    parameter int MAX_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [3:0]  slot,
    input  logic [15:0] arrival_tick,
    input  logic [15:0] burst_ticks,
    input  logic [7:0]  priority_level,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  running_slot,
    output logic        idle,
    output logic        finished,
    output logic [19:0] completion_tick,
    output logic [19:0] waiting_ticks,
    output logic [19:0] turnaround_ticks,
    output logic        all_done
);

    import pps_pkg::*;

    `include "preemptive_priority_scheduler_macros.svh"

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int NUM_W  = $clog2(MAX_SLOTS + 1);
    // wide enough for the slot count and the 5-bit register
    localparam int CNT_W  = (NUM_W > FIN_W) ? NUM_W : FIN_W;
    localparam int ENT_W  = $bits(slot_entry_t);

    // control state
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [SLOT_W-1:0]     pend_idx_reg;
    logic [MAX_SLOTS-1:0]  loaded_reg, loaded_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [FIN_W-1:0]      fin_reg, fin_next;
    logic [4:0]            count_reg;
    logic                  out_valid_reg, out_valid_next;

    // per-tick working values
    logic                  done_reg;
    logic [TICK_W-1:0]     comp_reg;
    logic [TICK_W-1:0]     turn_reg;

    // output payload
    logic [3:0]            o_slot_reg;
    logic                  o_idle_reg;
    logic                  o_fin_reg;
    logic [TICK_W-1:0]     o_comp_reg;
    logic [TICK_W-1:0]     o_wait_reg;
    logic [TICK_W-1:0]     o_turn_reg;
    logic                  o_all_reg;

    // memory port
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    slot_entry_t           ram_wdata;
    logic                  ram_re;
    slot_entry_t           ram_rdata;
    logic [ENT_W-1:0]      ram_rdata_bits;

    // picker
    pick_ctl_t             pick_ctl;
    logic                  pick_found;
    logic [SLOT_W-1:0]     pick_idx;
    slot_entry_t           pick_best;

    logic                  in_accept;
    logic                  load_hit;
    logic [CNT_W-1:0]      num_slots;
    logic [TICK_W-1:0]     comp_calc;
    logic [TICK_W-1:0]     arr_ext;
    logic [TICK_W-1:0]     burst_ext;
    logic [TICK_W-1:0]     wait_calc;
    logic                  emit_go;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    // process_count above the table size acts as the table size
    assign num_slots = (CNT_W'(count_reg) > CNT_W'(MAX_SLOTS)) ?
                       CNT_W'(MAX_SLOTS) : CNT_W'(count_reg);

    // loads to a slot beyond the table are dropped
    assign load_hit = in_accept && (cmd_t'(command) == CMD_LOAD)
                   && (CNT_W'(slot) < CNT_W'(MAX_SLOTS));

    // saturating completion and zero-floored waiting time of the picked slot
    assign arr_ext   = TICK_W'(pick_best.arrival);
    assign burst_ext = TICK_W'(pick_best.burst);
    assign comp_calc = (tick_reg == TICK_MAX) ? TICK_MAX : tick_reg + 1'b1;
    assign wait_calc = (turn_reg > burst_ext) ? turn_reg - burst_ext : '0;

    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    // slot memory: loads write in idle, the winner writes back in update and
    // reads happen only during scan, so no access pair can overlap
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = SLOT_W'(slot);
        ram_wdata = '{arrival: arrival_tick, burst: burst_ticks,
                      prio: priority_level, remaining: burst_ticks};
        if (load_hit)
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == ST_UPDATE) && pick_found)
        begin
            ram_we              = 1'b1;
            ram_waddr           = pick_idx;
            ram_wdata           = pick_best;
            ram_wdata.remaining = pick_best.remaining - 16'd1;
        end
    end

    assign ram_re = (state_reg == ST_SCAN) && (idx_reg < num_slots);

    pps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = slot_entry_t'(ram_rdata_bits);

    assign pick_ctl = '{clear: in_accept && (cmd_t'(command) == CMD_TICK),
                        eval:  (state_reg == ST_SCAN) && pend_reg};

    pps_picker #(
        .SLOT_W (SLOT_W)
    ) u_picker (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (pick_ctl),
        .cand_idx    (pend_idx_reg),
        .cand        (ram_rdata),
        .cand_loaded (loaded_reg[pend_idx_reg]),
        .now_tick    (tick_reg),
        .found       (pick_found),
        .best_idx    (pick_idx),
        .best        (pick_best)
    );

    // sequencer: next state and control
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        loaded_next    = loaded_reg;
        tick_next      = tick_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (load_hit)
        begin
            loaded_next[SLOT_W'(slot)] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (cmd_t'(command) == CMD_TICK))
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one read issued per cycle, its data evaluated the next
                if (ram_re)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (pick_found && (pick_best.remaining == 16'd1)
                    && (fin_reg != FIN_MAX))
                begin
                    fin_next = fin_reg + 1'b1;
                end
                if (tick_reg != TICK_MAX)
                begin
                    tick_next = tick_reg + 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            loaded_reg    <= '0;
            tick_reg      <= '0;
            fin_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            loaded_reg    <= loaded_next;
            tick_reg      <= tick_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            pend_idx_reg <= idx_reg[SLOT_W-1:0];
        end
        if (state_reg == ST_UPDATE)
        begin
            // times read zero unless the slot finished on this tick
            done_reg <= pick_found && (pick_best.remaining == 16'd1);
            if (pick_found && (pick_best.remaining == 16'd1))
            begin
                comp_reg <= comp_calc;
                turn_reg <= (comp_calc > arr_ext) ? comp_calc - arr_ext : '0;
            end
            else
            begin
                comp_reg <= '0;
                turn_reg <= '0;
            end
        end
        if (emit_go)
        begin
            o_slot_reg <= pick_found ? 4'(pick_idx) : 4'd0;
            o_idle_reg <= !pick_found;
            o_fin_reg  <= done_reg;
            o_comp_reg <= comp_reg;
            o_turn_reg <= turn_reg;
            o_wait_reg <= wait_calc;
            o_all_reg  <= (CNT_W'(fin_reg) >= num_slots);
        end
    end

    assign out_valid        = out_valid_reg;
    assign running_slot     = o_slot_reg;
    assign idle             = o_idle_reg;
    assign finished         = o_fin_reg;
    assign completion_tick  = o_comp_reg;
    assign waiting_ticks    = o_wait_reg;
    assign turnaround_ticks = o_turn_reg;
    assign all_done         = o_all_reg;

    // the slot memory is never written while the scan reads it
    `PPS_ASSERT_NOW(a_no_write_in_scan, clk, rst_n, state_reg == ST_SCAN, !ram_we, "write during scan")
    // a tick item always starts a scan
    `PPS_ASSERT_NEXT(a_tick_scans, clk, rst_n, in_accept && command, state_reg == ST_SCAN, "tick did not scan")
    // a finished result names a running slot and has consistent times
    `PPS_ASSERT_NOW(a_fin_sane, clk, rst_n, out_valid && finished, !idle && (turnaround_ticks >= waiting_ticks), "bad finished result")
    // time never runs backward
    `PPS_ASSERT_NEXT(a_tick_mono, clk, rst_n, 1'b1, tick_reg >= $past(tick_reg), "tick went backward")

endmodule

### hw/rtl/pps_ram.sv
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/pps_picker.sv
module pps_picker #(
    parameter int SLOT_W = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pps_pkg::pick_ctl_t              ctl,
    input  logic [SLOT_W-1:0]               cand_idx,
    input  pps_pkg::slot_entry_t            cand,
    input  logic                            cand_loaded,
    input  logic [pps_pkg::TICK_W-1:0]      now_tick,
    output logic                            found,
    output logic [SLOT_W-1:0]               best_idx,
    output pps_pkg::slot_entry_t            best
);

    import pps_pkg::*;

    logic        found_reg;
    logic        found_next;
    logic [SLOT_W-1:0] best_idx_reg;
    slot_entry_t best_reg;
    logic        ready;
    logic        take;

    // ready: loaded, work left, arrived by now
    assign ready = cand_loaded && (cand.remaining != 16'd0)
                && (TICK_W'(cand.arrival) <= now_tick);
    // strictly higher priority replaces, so the lowest index keeps a tie
    assign take = ctl.eval && ready && (!found_reg || (cand.prio > best_reg.prio));

    always_comb
    begin
        found_next = found_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= cand_idx;
            best_reg     <= cand;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best     = best_reg;

endmodule
